### rtl/keymap_layer_engine_assert.svh
// ----------------------------------------------------------------------------
// Keymap layer engine assertion macros
// Clocked, reset-qualified assertion forms used by the engine core.
// ----------------------------------------------------------------------------
`ifndef KEYMAP_LAYER_ENGINE_ASSERT_SVH
`define KEYMAP_LAYER_ENGINE_ASSERT_SVH

// same-cycle implication
`define KLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("keymap layer engine: check failed");

// next-cycle implication
`define KLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keymap layer engine: check failed");

`endif

### rtl/kle_pkg.sv
// ----------------------------------------------------------------------------
// Keymap layer engine package
// Word types, register indexes, codes and default parameter values.
// ----------------------------------------------------------------------------
package kle_pkg;

    localparam int CODE_W        = 16;
    localparam int ROW_W         = 3;
    localparam int COL_W         = 4;
    localparam int MAP_LAYER_W   = 2;
    localparam int SLOT_W        = 3;
    localparam int LAYER_W       = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int REPORT_FIELDS = 6;

    localparam int SLOTS_DEF  = 6;
    localparam int LAYERS_DEF = 4;
    localparam int ROWS_DEF   = 8;
    localparam int COLS_DEF   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTARY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_LAYER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_XPORT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 2'd3;

    localparam logic [CODE_W-1:0] RST_MOMENTARY    = 16'd65533;
    localparam logic [CODE_W-1:0] RST_TOGGLE_LAYER = 16'd65534;
    localparam logic [CODE_W-1:0] RST_TOGGLE_XPORT = 16'd65535;
    localparam logic [CODE_W-1:0] RST_TRANSPARENT  = 16'd0;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    localparam logic [LAYER_W-1:0] LAYER_BASE      = 2'd0;
    localparam logic [LAYER_W-1:0] LAYER_MOMENTARY = 2'd1;
    localparam logic [LAYER_W-1:0] LAYER_TOGGLE    = 2'd2;
    localparam logic [LAYER_W-1:0] LAYER_UNUSED    = 2'd3;

    typedef enum logic [1:0] {
        PEND_NONE      = 2'd0,
        PEND_LAYER     = 2'd1,
        PEND_TRANSPORT = 2'd2
    } t_pending;

    typedef struct packed {
        logic                   cmd;
        logic [SLOT_W-1:0]      slot_index;
        logic                   key_present;
        logic [ROW_W-1:0]       key_row;
        logic [COL_W-1:0]       key_col;
        logic [MAP_LAYER_W-1:0] map_layer;
        logic [CODE_W-1:0]      map_code;
        logic                   matrix_changed;
    } t_in_word;

    typedef struct packed {
        logic [CODE_W-1:0]  report_code0;
        logic [CODE_W-1:0]  report_code1;
        logic [CODE_W-1:0]  report_code2;
        logic [CODE_W-1:0]  report_code3;
        logic [CODE_W-1:0]  report_code4;
        logic [CODE_W-1:0]  report_code5;
        logic               transport_sel;
        logic [LAYER_W-1:0] layer_now;
    } t_out_word;

    typedef struct packed {
        logic [CODE_W-1:0] momentary;
        logic [CODE_W-1:0] toggle_layer;
        logic [CODE_W-1:0] toggle_xport;
        logic [CODE_W-1:0] transparent;
    } t_cfg_codes;

    typedef struct packed {
        logic                   wr;
        logic                   rd;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
        logic [MAP_LAYER_W-1:0] layer;
        logic [CODE_W-1:0]      code;
    } t_map_req;

endpackage

### rtl/kle_in_if.sv
// ----------------------------------------------------------------------------
// Keymap layer engine input channel
// Valid/ready channel carrying one scan or keymap-write word.
// ----------------------------------------------------------------------------
interface kle_in_if;
    logic              valid;
    logic              ready;
    kle_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/kle_out_if.sv
// ----------------------------------------------------------------------------
// Keymap layer engine output channel
// Valid/ready channel carrying one report word.
// ----------------------------------------------------------------------------
interface kle_out_if;
    logic               valid;
    logic               ready;
    kle_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/kle_keymap.sv
// ----------------------------------------------------------------------------
// Keymap store
// One row per matrix position holding every layer's code; lane write,
// full-row registered read.
// ----------------------------------------------------------------------------
module kle_keymap #(
    parameter int LAYERS = kle_pkg::LAYERS_DEF,
    parameter int ROWS   = kle_pkg::ROWS_DEF,
    parameter int COLS   = kle_pkg::COLS_DEF
) (
    input  logic                                    i_clk,
    input  kle_pkg::t_map_req                       i_req,
    output logic [LAYERS-1:0][kle_pkg::CODE_W-1:0]  o_rd_data,
    output logic                                    o_rd_ok
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(LAYERS);

    logic [LAYERS-1:0][kle_pkg::CODE_W-1:0] r_mem [DEPTH];
    logic [LAYERS-1:0][kle_pkg::CODE_W-1:0] r_rd_data;
    logic                                   r_rd_ok;

    logic          pos_ok;
    logic          lay_ok;
    logic [AW-1:0] addr;
    logic [LW-1:0] lane;

    assign pos_ok = (int'(i_req.row) < ROWS) && (int'(i_req.col) < COLS);
    assign lay_ok = int'(i_req.layer) < LAYERS;
    assign addr   = AW'(int'(i_req.row) * COLS + int'(i_req.col));
    assign lane   = LW'(i_req.layer);

    always_ff @(posedge i_clk) begin
        if (i_req.wr && pos_ok && lay_ok) begin
            r_mem[addr][lane] <= i_req.code;
        end
        if (i_req.rd) begin
            r_rd_data <= r_mem[addr];
            r_rd_ok   <= pos_ok;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_ok   = r_rd_ok;

endmodule

### rtl/kle_core.sv
// ----------------------------------------------------------------------------
// Keymap layer engine core
// Item register, layer and report state, single-pass slot update and
// report register.
// ----------------------------------------------------------------------------
`include "keymap_layer_engine_assert.svh"

module kle_core #(
    parameter int SLOTS  = kle_pkg::SLOTS_DEF,
    parameter int LAYERS = kle_pkg::LAYERS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  kle_pkg::t_cfg_codes                     i_cfg,
    kle_in_if.sink                                  i_in,
    kle_out_if.source                               o_out,
    output kle_pkg::t_map_req                       o_map_req,
    input  logic [LAYERS-1:0][kle_pkg::CODE_W-1:0]  i_rd_data,
    input  logic                                    i_rd_ok
);

    localparam int LW = $clog2(LAYERS);

    // item stage
    logic              r_s1_valid;
    kle_pkg::t_in_word r_s1;

    // engine state
    logic [kle_pkg::LAYER_W-1:0] r_active, n_active;
    logic [kle_pkg::LAYER_W-1:0] r_base, n_base;
    logic [kle_pkg::ROW_W-1:0]   r_hold_row, n_hold_row;
    logic [kle_pkg::COL_W-1:0]   r_hold_col, n_hold_col;
    logic                        r_hold_valid, n_hold_valid;
    logic                        r_pos_valid [SLOTS];
    logic                        n_pos_valid [SLOTS];
    logic [kle_pkg::ROW_W-1:0]   r_pos_row [SLOTS];
    logic [kle_pkg::ROW_W-1:0]   n_pos_row [SLOTS];
    logic [kle_pkg::COL_W-1:0]   r_pos_col [SLOTS];
    logic [kle_pkg::COL_W-1:0]   n_pos_col [SLOTS];
    logic [kle_pkg::CODE_W-1:0]  r_codes [SLOTS];
    logic [kle_pkg::CODE_W-1:0]  n_codes [SLOTS];
    kle_pkg::t_pending           r_pending, n_pending;
    logic                        r_xport, n_xport;

    // report stage
    logic               r_out_valid;
    kle_pkg::t_out_word r_out_word;
    kle_pkg::t_out_word n_out_word;

    logic                       in_accept;
    logic                       s1_scan;
    logic                       s1_slot_ok;
    logic                       s1_closing;
    logic                       s1_result;
    logic                       s1_fire;
    logic [kle_pkg::CODE_W-1:0] code_act;
    logic [kle_pkg::CODE_W-1:0] code_base;
    logic [kle_pkg::CODE_W-1:0] rep [kle_pkg::REPORT_FIELDS];

    assign s1_scan    = r_s1.cmd == kle_pkg::CMD_SCAN;
    assign s1_slot_ok = int'(r_s1.slot_index) < SLOTS;
    assign s1_closing = int'(r_s1.slot_index) == SLOTS - 1;
    assign s1_result  = s1_scan && s1_slot_ok && s1_closing && r_s1.matrix_changed;
    assign s1_fire    = r_s1_valid && (!s1_result || !r_out_valid || o_out.ready);

    assign i_in.ready = !r_s1_valid || s1_fire;
    assign in_accept  = i_in.valid && i_in.ready;

    always_comb begin
        o_map_req.wr    = in_accept && (i_in.data.cmd == kle_pkg::CMD_MAP);
        o_map_req.rd    = in_accept;
        o_map_req.row   = i_in.data.key_row;
        o_map_req.col   = i_in.data.key_col;
        o_map_req.layer = i_in.data.map_layer;
        o_map_req.code  = i_in.data.map_code;
    end

    assign code_act  = i_rd_ok ? i_rd_data[LW'(r_active)] : '0;
    assign code_base = i_rd_ok ? i_rd_data[LW'(r_base)] : '0;

    always_comb begin
        int                         k;
        logic                       held;
        logic                       down;
        logic [kle_pkg::CODE_W-1:0] pend_code;
        n_active     = r_active;
        n_base       = r_base;
        n_hold_row   = r_hold_row;
        n_hold_col   = r_hold_col;
        n_hold_valid = r_hold_valid;
        n_pos_valid  = r_pos_valid;
        n_pos_row    = r_pos_row;
        n_pos_col    = r_pos_col;
        n_codes      = r_codes;
        n_pending    = r_pending;
        n_xport      = r_xport;
        held         = 1'b0;
        down         = 1'b0;
        pend_code    = (r_pending == kle_pkg::PEND_LAYER) ? i_cfg.toggle_layer
                                                          : i_cfg.toggle_xport;
        if (s1_fire && s1_scan && s1_slot_ok) begin
            for (k = 0; k < SLOTS; k++) begin
                if (int'(r_s1.slot_index) == k) begin
                    n_pos_valid[k] = r_s1.key_present;
                    if (r_s1.key_present) begin
                        n_pos_row[k] = r_s1.key_row;
                        n_pos_col[k] = r_s1.key_col;
                        if (code_act != i_cfg.momentary && !(r_hold_valid
                                && r_hold_row == r_s1.key_row
                                && r_hold_col == r_s1.key_col)) begin
                            n_codes[k] = (code_act == i_cfg.transparent) ? code_base
                                                                         : code_act;
                        end
                    end else begin
                        n_codes[k] = '0;
                    end
                end
            end
            if (r_s1.key_present) begin
                if (code_act == i_cfg.momentary) begin
                    n_base       = r_active;
                    n_active     = kle_pkg::LAYER_MOMENTARY;
                    n_hold_row   = r_s1.key_row;
                    n_hold_col   = r_s1.key_col;
                    n_hold_valid = 1'b1;
                end else if ((code_act == i_cfg.toggle_layer
                        || code_act == i_cfg.toggle_xport)
                        && r_pending == kle_pkg::PEND_NONE) begin
                    n_pending = (code_act == i_cfg.toggle_layer) ? kle_pkg::PEND_LAYER
                                                                 : kle_pkg::PEND_TRANSPORT;
                end
            end
            if (s1_closing) begin
                // drop the momentary layer once its key is gone
                if (n_active != n_base) begin
                    for (k = 0; k < SLOTS; k++) begin
                        if (n_hold_valid && n_pos_valid[k] && n_pos_row[k] == n_hold_row
                                && n_pos_col[k] == n_hold_col) begin
                            held = 1'b1;
                        end
                    end
                    if (!held) begin
                        n_active     = n_base;
                        n_hold_valid = 1'b0;
                    end
                end
                // on a changed scan, run the armed function once its code is released
                if (r_s1.matrix_changed && n_pending != kle_pkg::PEND_NONE) begin
                    pend_code = (n_pending == kle_pkg::PEND_LAYER) ? i_cfg.toggle_layer
                                                                   : i_cfg.toggle_xport;
                    for (k = 0; k < SLOTS; k++) begin
                        if (n_codes[k] == pend_code) begin
                            down = 1'b1;
                        end
                    end
                    if (!down) begin
                        if (n_pending == kle_pkg::PEND_LAYER) begin
                            n_active = (n_active == kle_pkg::LAYER_TOGGLE)
                                       ? kle_pkg::LAYER_BASE : kle_pkg::LAYER_TOGGLE;
                            n_base   = n_active;
                        end else if (n_pending == kle_pkg::PEND_TRANSPORT) begin
                            n_xport = !n_xport;
                        end
                        n_pending = kle_pkg::PEND_NONE;
                    end
                end
            end
        end
    end

    for (genvar g = 0; g < kle_pkg::REPORT_FIELDS; g++) begin : g_rep
        if (g < SLOTS) begin : g_on
            assign rep[g] = n_codes[g];
        end else begin : g_off
            assign rep[g] = '0;
        end
    end

    always_comb begin
        n_out_word.report_code0  = rep[0];
        n_out_word.report_code1  = rep[1];
        n_out_word.report_code2  = rep[2];
        n_out_word.report_code3  = rep[3];
        n_out_word.report_code4  = rep[4];
        n_out_word.report_code5  = rep[5];
        n_out_word.transport_sel = n_xport;
        n_out_word.layer_now     = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_active     <= kle_pkg::LAYER_BASE;
            r_base       <= kle_pkg::LAYER_BASE;
            r_hold_row   <= '0;
            r_hold_col   <= '0;
            r_hold_valid <= 1'b0;
            r_pending    <= kle_pkg::PEND_NONE;
            r_xport      <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_pos_valid[k] <= 1'b0;
                r_pos_row[k]   <= '0;
                r_pos_col[k]   <= '0;
                r_codes[k]     <= '0;
            end
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && s1_result) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_active     <= n_active;
            r_base       <= n_base;
            r_hold_row   <= n_hold_row;
            r_hold_col   <= n_hold_col;
            r_hold_valid <= n_hold_valid;
            r_pos_valid  <= n_pos_valid;
            r_pos_row    <= n_pos_row;
            r_pos_col    <= n_pos_col;
            r_codes      <= n_codes;
            r_pending    <= n_pending;
            r_xport      <= n_xport;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in.data;
        end
        if (s1_fire && s1_result) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    `KLE_ASSERT_NEXT(a_result_lands, s1_fire && s1_result, r_out_valid)
    `KLE_ASSERT_NEXT(a_stall_holds_item, r_s1_valid && !s1_fire, r_s1_valid)
    `KLE_ASSERT_NOW(a_free_stage_ready, !r_s1_valid, i_in.ready)
    `KLE_ASSERT_NOW(a_layer_known, 1'b1, r_active != kle_pkg::LAYER_UNUSED && r_base != kle_pkg::LAYER_UNUSED)

endmodule

### rtl/keymap_layer_engine.sv
// ----------------------------------------------------------------------------
// Keymap layer engine
// Translates scan slots through a layered keymap and emits a report word
// at the close of each changed scan.
//
//   channel   dir  payload                         accepted when
//   i_in      in   t_in_word (scan / map write)    valid && ready
//   o_out     out  t_out_word (report)             valid && ready
//   i_cfg_*   in   register index and code         i_cfg_we
//
// One word per cycle while no waiting report holds the item stage. The keymap
// row is read at the edge that takes the word into the item register, and the
// slot update lands in the report register when the item stage fires, so a
// report passes the item register and then the report register. The keymap row
// holds all layers, so base-layer fallback needs no second read. A waiting
// report holds the item stage only when that stage itself carries a report.
// Reset clears all layer, slot and handshake state; the keymap is undefined until written.
// ----------------------------------------------------------------------------
module keymap_layer_engine #(
    parameter int SLOTS  = kle_pkg::SLOTS_DEF,
    parameter int LAYERS = kle_pkg::LAYERS_DEF,
    parameter int ROWS   = kle_pkg::ROWS_DEF,
    parameter int COLS   = kle_pkg::COLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kle_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kle_pkg::CODE_W-1:0]      i_cfg_data,
    kle_in_if.sink                          i_in,
    kle_out_if.source                       o_out
);

    logic [kle_pkg::CODE_W-1:0] r_code_mom;
    logic [kle_pkg::CODE_W-1:0] r_code_tl;
    logic [kle_pkg::CODE_W-1:0] r_code_tt;
    logic [kle_pkg::CODE_W-1:0] r_code_tr;

    kle_pkg::t_cfg_codes                    cfg;
    kle_pkg::t_map_req                      map_req;
    logic [LAYERS-1:0][kle_pkg::CODE_W-1:0] rd_data;
    logic                                   rd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_mom <= kle_pkg::RST_MOMENTARY;
            r_code_tl  <= kle_pkg::RST_TOGGLE_LAYER;
            r_code_tt  <= kle_pkg::RST_TOGGLE_XPORT;
            r_code_tr  <= kle_pkg::RST_TRANSPARENT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kle_pkg::CFG_MOMENTARY:    r_code_mom <= i_cfg_data;
                kle_pkg::CFG_TOGGLE_LAYER: r_code_tl  <= i_cfg_data;
                kle_pkg::CFG_TOGGLE_XPORT: r_code_tt  <= i_cfg_data;
                kle_pkg::CFG_TRANSPARENT:  r_code_tr  <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        cfg.momentary    = r_code_mom;
        cfg.toggle_layer = r_code_tl;
        cfg.toggle_xport = r_code_tt;
        cfg.transparent  = r_code_tr;
    end

    kle_keymap #(
        .LAYERS (LAYERS),
        .ROWS   (ROWS),
        .COLS   (COLS)
    ) u_keymap (
        .i_clk     (i_clk),
        .i_req     (map_req),
        .o_rd_data (rd_data),
        .o_rd_ok   (rd_ok)
    );

    kle_core #(
        .SLOTS  (SLOTS),
        .LAYERS (LAYERS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_map_req (map_req),
        .i_rd_data (rd_data),
        .i_rd_ok   (rd_ok)
    );

endmodule
